// ===== hw/rtl/integer_to_ascii_formatter_top_assert.svh =====
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITOA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/itoa_pkg.sv =====
package itoa_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CharW  = 8;

  // Ten BCD digits cover the full 32-bit magnitude; eight nibbles cover hex.
  localparam int unsigned DigW     = 40;
  localparam logic [3:0]  NumDecDig = 4'd10;
  localparam logic [3:0]  NumHexDig = 4'd8;

  localparam logic [CmdW-1:0] CMD_CHAR = 3'd0;
  localparam logic [CmdW-1:0] CMD_DEC  = 3'd1;
  localparam logic [CmdW-1:0] CMD_HEX  = 3'd2;
  localparam logic [CmdW-1:0] CMD_PTR  = 3'd3;

  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_A     = 8'h61;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_NUL   = 8'h00;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib <= 4'd9) begin
      c = CH_ZERO + {4'h0, nib};
    end else begin
      c = CH_A + {4'h0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_formatter_top.sv =====
// Formats one 32-bit value per item as ASCII text, one character per output item,
// with tlast on the final character and tuser high when the command was known.
// Commands on s_axis_tuser: 0 one raw byte, 1 signed decimal, 2 lower-case hex,
// 3 "0x" plus hex; anything else gives a single zero byte with tuser low.
// One item is worked on at a time. A raw byte or unknown command is registered as
// its one output character on accept. Hex accepts the item, skips leading zero
// nibbles one at a time, finds the first digit and sends the text. Decimal runs a
// bit-serial binary to BCD conversion over all 32 bits, then skips leading zero
// digits and sends the text. Text goes out one character a cycle while the
// output is not stalled; a stall holds each character until it is taken.
module integer_to_ascii_formatter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [itoa_pkg::ValueW-1:0]   s_axis_tdata,  // [31:0] value
  input  logic [itoa_pkg::CmdW-1:0]     s_axis_tuser,  // [2:0] command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [itoa_pkg::CharW-1:0]    m_axis_tdata,  // [7:0] out_char
  output logic                          m_axis_tlast,  // last
  output logic                          m_axis_tuser   // [0] chars_used
);
  import itoa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [DigW-1:0]     dig_q;
  logic [ValueW-1:0]   bin_q;
  logic [4:0]          cnt_q;
  logic [3:0]          ndig_q;
  logic [1:0]          pfx_q;
  logic                dec_q;
  logic                out_valid_q;
  logic [CharW-1:0]    out_char_q;
  logic                out_last_q;
  logic                out_used_q;

  logic                ld;
  logic [DigW-1:0]     adj;
  logic [ValueW-1:0]   neg_val;
  logic [CharW-1:0]    pfx_char;

  assign ld            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && ld;
  assign neg_val       = {ValueW{1'b0}} - s_axis_tdata;
  assign pfx_char      = dec_q ? CH_MINUS : ((pfx_q == 2'd2) ? CH_ZERO : CH_X);

  // Add three to every BCD digit of five or more before the next shift.
  always_comb begin
    adj = dig_q;
    for (int i = 0; i < DigW / 4; i++) begin
      if (dig_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig_q[4*i +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dig_q       <= '0;
      bin_q       <= '0;
      cnt_q       <= '0;
      ndig_q      <= '0;
      pfx_q       <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_used_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            unique case (s_axis_tuser)
              CMD_CHAR: begin
                out_valid_q <= 1'b1;
                out_char_q  <= s_axis_tdata[CharW-1:0];
                out_last_q  <= 1'b1;
                out_used_q  <= 1'b1;
              end
              CMD_DEC: begin
                out_valid_q <= 1'b0;
                dec_q       <= 1'b1;
                pfx_q       <= {1'b0, s_axis_tdata[ValueW-1]};
                bin_q       <= s_axis_tdata[ValueW-1] ? neg_val : s_axis_tdata;
                dig_q       <= '0;
                cnt_q       <= '1;
                ndig_q      <= NumDecDig;
                state_q     <= S_CONV;
              end
              CMD_HEX, CMD_PTR: begin
                out_valid_q <= 1'b0;
                dec_q       <= 1'b0;
                pfx_q       <= (s_axis_tuser == CMD_PTR) ? 2'd2 : 2'd0;
                dig_q       <= {s_axis_tdata, {(DigW-ValueW){1'b0}}};
                ndig_q      <= NumHexDig;
                state_q     <= S_SKIP;
              end
              default: begin
                out_valid_q <= 1'b1;
                out_char_q  <= CH_NUL;
                out_last_q  <= 1'b1;
                out_used_q  <= 1'b0;
              end
            endcase
          end else if (m_axis_tready) begin
            // Drop the previous item's last character once taken.
            out_valid_q <= 1'b0;
          end
        end
        S_CONV: begin
          dig_q <= {adj[DigW-2:0], bin_q[ValueW-1]};
          bin_q <= {bin_q[ValueW-2:0], 1'b0};
          cnt_q <= cnt_q - 5'd1;
          if (cnt_q == 5'd0) begin
            state_q <= S_SKIP;
          end
        end
        S_SKIP: begin
          // Drop leading zero digits, keeping at least one.
          if (dig_q[DigW-1 -: 4] == 4'd0 && ndig_q > 4'd1) begin
            dig_q  <= {dig_q[DigW-5:0], 4'h0};
            ndig_q <= ndig_q - 4'd1;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (ld) begin
            out_valid_q <= 1'b1;
            out_used_q  <= 1'b1;
            if (pfx_q != 2'd0) begin
              out_char_q <= pfx_char;
              out_last_q <= 1'b0;
              pfx_q      <= pfx_q - 2'd1;
            end else begin
              out_char_q <= digit_char(dig_q[DigW-1 -: 4]);
              out_last_q <= (ndig_q == 4'd1);
              dig_q      <= {dig_q[DigW-5:0], 4'h0};
              ndig_q     <= ndig_q - 4'd1;
              if (ndig_q == 4'd1) begin
                state_q <= S_IDLE;
              end
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_used_q;

`include "integer_to_ascii_formatter_top_assert.svh"

  `ITOA_ASSERT_SAME(a_emit_has_digit, state_q == S_EMIT, ndig_q != 4'd0, "digit count ran out")
  `ITOA_ASSERT_NEXT(a_conv_to_skip, state_q == S_CONV && cnt_q == 5'd0, state_q == S_SKIP, "overran")
  `ITOA_ASSERT_SAME(a_bcd_digit, state_q == S_EMIT && dec_q, dig_q[DigW-1 -: 4] <= 4'd9, "bad BCD")
  `ITOA_ASSERT_SAME(a_text_open, m_axis_tvalid && !m_axis_tlast, state_q == S_EMIT, "early end")

endmodule
